[rtl/core/tvq_pkg.sv]
// Shared constants, types and helpers for the threshold vector quantiser.
package tvq_pkg;

	localparam int VECTOR_LEN   = 5;
	localparam int DICT_ENTRIES = 1024;

	localparam int BYTE_W    = 8;
	localparam int VEC_W     = VECTOR_LEN * BYTE_W;
	localparam int POS_W     = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
	localparam int ADDR_W    = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
	localparam int CNT_W     = $clog2(DICT_ENTRIES + 1);
	localparam int THR_W     = 9;
	localparam int OUT_IDX_W = 10;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 24;
	localparam int OUT_USER_W = 2;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(5);

	// result of one vector search, handed to the output stage
	typedef struct packed {
		logic [VEC_W-1:0]     vec;
		logic [OUT_IDX_W-1:0] idx;
		logic                 hit;
		logic                 full;
	} res_t;

	// dictionary address masked to the output index width
	function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [ADDR_W-1:0] a);
		logic [ADDR_W+OUT_IDX_W-1:0] w;
		w = {{OUT_IDX_W{1'b0}}, a};
		return w[OUT_IDX_W-1:0];
	endfunction

endpackage

[rtl/core/tvq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tvq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

[rtl/core/tvq_gather.sv]
// Input byte gatherer: assembles one vector and holds it until released.
module tvq_gather (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [tvq_pkg::BYTE_W-1:0] in_byte,
	input  logic                     release_vec,
	output logic                     vec_full,
	output logic [tvq_pkg::VEC_W-1:0] vec
);
	import tvq_pkg::*;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(VECTOR_LEN - 1);

	logic [BYTE_W-1:0] buf_q [VECTOR_LEN];
	logic [POS_W-1:0]  pos_q;
	logic              full_q;
	logic              take;

	assign in_ready = !full_q;
	assign take     = in_valid && !full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			full_q <= 1'b0;
		end else begin
			if (take) begin
				if (pos_q == LAST_POS) begin
					pos_q  <= '0;
					full_q <= 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end else if (release_vec) begin
				full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			buf_q[pos_q] <= in_byte;
		end
	end

	always_comb begin
		for (int k = 0; k < VECTOR_LEN; k++) begin
			vec[k*BYTE_W +: BYTE_W] = buf_q[k];
		end
	end

	assign vec_full = full_q;
endmodule

[rtl/core/tvq_search.sv]
// Dictionary search engine: scans the store one entry a cycle, appends on miss while the store has room.
module tvq_search (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tvq_pkg::VEC_W-1:0] vec,
	input  logic [tvq_pkg::THR_W-1:0] max_dist,
	output logic                      res_valid,
	input  logic                      res_ready,
	output tvq_pkg::res_t             res
);
	import tvq_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DICT_ENTRIES);

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  addr_q;
	logic              chk_v_s1;
	logic [ADDR_W-1:0] chk_addr_s1;
	res_t              res_q;

	logic              rd_en;
	logic [VEC_W-1:0]  rd_data;
	logic              fits;
	logic              hit_now;
	logic              miss_now;
	logic              wr_en;

	// every byte difference strictly below the threshold
	always_comb begin
		logic [BYTE_W-1:0] a, b, d;
		fits = 1'b1;
		for (int k = 0; k < VECTOR_LEN; k++) begin
			a = vec[k*BYTE_W +: BYTE_W];
			b = rd_data[k*BYTE_W +: BYTE_W];
			d = (a > b) ? (a - b) : (b - a);
			if ({1'b0, d} >= max_dist) begin
				fits = 1'b0;
			end
		end
	end

	assign hit_now  = (state_q == S_SCAN) && chk_v_s1 && fits;
	assign miss_now = ((state_q == S_IDLE) && start && (count_q == '0)) ||
	                  ((state_q == S_SCAN) && !chk_v_s1 && (addr_q == count_q));
	assign rd_en    = (state_q == S_SCAN) && !hit_now && (addr_q < count_q);
	assign wr_en    = miss_now && (count_q < CNT_MAX);

	tvq_ram #(
		.WIDTH(VEC_W),
		.DEPTH(DICT_ENTRIES)
	) u_dict (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[ADDR_W-1:0]),
		.wr_data(vec),
		.rd_en  (rd_en),
		.rd_addr(addr_q[ADDR_W-1:0]),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			addr_q      <= '0;
			chk_v_s1    <= 1'b0;
			chk_addr_s1 <= '0;
			res_q       <= '0;
		end else begin
			chk_v_s1 <= rd_en;
			if (rd_en) begin
				chk_addr_s1 <= addr_q[ADDR_W-1:0];
				addr_q      <= addr_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (start && (count_q != '0)) begin
						addr_q  <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit_now) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (hit_now) begin
				res_q.vec  <= rd_data;
				res_q.idx  <= to_out_idx(chk_addr_s1);
				res_q.hit  <= 1'b1;
				res_q.full <= 1'b0;
			end
			if (miss_now) begin
				state_q   <= S_DONE;
				res_q.vec <= vec;
				res_q.hit <= 1'b0;
				if (wr_en) begin
					res_q.idx  <= to_out_idx(count_q[ADDR_W-1:0]);
					res_q.full <= 1'b0;
					count_q    <= count_q + 1'b1;
				end else begin
					res_q.idx  <= '0;
					res_q.full <= 1'b1;
				end
			end
		end
	end

	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;
endmodule

[rtl/core/tvq_emit.sv]
// Output serialiser: sends one search result as a run of byte words.
module tvq_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          res_valid,
	output logic                          res_ready,
	input  tvq_pkg::res_t                 res,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tvq_pkg::OUT_DATA_W-1:0] out_data,
	output logic [tvq_pkg::OUT_USER_W-1:0] out_user,
	output logic                          out_last
);
	import tvq_pkg::*;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(VECTOR_LEN - 1);
	localparam int PAD_W = OUT_DATA_W - BYTE_W - OUT_IDX_W;

	res_t             res_q;
	logic             busy_q;
	logic [POS_W-1:0] pos_q;
	logic [BYTE_W-1:0] cur_byte;

	assign res_ready = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else begin
			if (!busy_q && res_valid) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end else if (busy_q && out_ready) begin
				if (pos_q == LAST_POS) begin
					busy_q <= 1'b0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && res_valid) begin
			res_q <= res;
		end
	end

	assign cur_byte  = res_q.vec[pos_q*BYTE_W +: BYTE_W];
	assign out_valid = busy_q;
	assign out_data  = {{PAD_W{1'b0}}, res_q.idx, cur_byte};
	assign out_user  = {res_q.full, res_q.hit};
	assign out_last  = (pos_q == LAST_POS);
endmodule

[rtl/core/threshold_vector_quantizer_top.sv]
// Top level of the threshold vector quantiser: gather, dictionary search and output stages.
// Search: after the last byte of a vector the dictionary is read one entry a cycle from registered
//   RAM read data, stopping at the first match; the result then passes to the output stage, which
//   offers the first word and the rest one a cycle while the sink keeps up.
// Overlap: the next vector's bytes are taken while the previous result's words drain.
// Reset: arst_n clears control state; threshold returns to 5, the store is empty (RAM kept).
module threshold_vector_quantizer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// input stream, tdata: [7:0] in_byte
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tvq_pkg::IN_DATA_W-1:0]  s_tdata,
	// output stream, tdata: [7:0] out_byte, [17:8] entry_index, rest zero
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tvq_pkg::OUT_DATA_W-1:0] m_tdata,
	// tuser: [0] matched, [1] unstored_full
	output logic [tvq_pkg::OUT_USER_W-1:0] m_tuser,
	output logic                           m_tlast,
	// threshold write channel: cfg_data = max_distortion
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tvq_pkg::THR_W-1:0]      cfg_data
);
	import tvq_pkg::*;

	logic [THR_W-1:0] max_dist_q;
	logic [VEC_W-1:0] vec;
	logic             vec_full;
	logic             res_valid;
	logic             res_ready;
	logic             res_take;
	res_t             res;

	// threshold register, always writable; it should only be written while idle, which the block does not enforce
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_q <= THR_RESET;
		end else if (cfg_valid) begin
			max_dist_q <= cfg_data;
		end
	end

	// the gathered vector stays put until its result moves to the output stage
	assign res_take = res_valid && res_ready;

	tvq_gather u_gather (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata[BYTE_W-1:0]),
		.release_vec(res_take),
		.vec_full   (vec_full),
		.vec        (vec)
	);

	// search starts when a vector is complete; it ignores start outside idle
	tvq_search u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (vec_full && !res_valid),
		.vec      (vec),
		.max_dist (max_dist_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// output register stage: the next vector may gather while words drain
	tvq_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata),
		.out_user (m_tuser),
		.out_last (m_tlast)
	);
endmodule

[rtl/core/tvq_checker.sv]
// Port-level checker for the threshold vector quantiser, bound to the top level.
module tvq_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [tvq_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic [tvq_pkg::OUT_USER_W-1:0] m_tuser,
	input  logic                           m_tlast
);
	import tvq_pkg::*;

	// a stalled word holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	// a vector's words follow back to back until tlast
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("vector run broken before last word");

	// matched and unstored are exclusive
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("matched and unstored_full both set");

	// an unstored vector reports index zero
	a_unstored_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[BYTE_W +: OUT_IDX_W] == '0)
		else $error("unstored vector with non-zero index");

	// flags stay constant across the words of one vector
	a_flags_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> $stable(m_tuser))
		else $error("flags changed within a vector");
endmodule

bind threshold_vector_quantizer_top tvq_checker u_tvq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);
